// File: rtl/sdd_pkg.sv
// Package with the shared types and constants of the value-to-digits block.
`timescale 1ns / 1ps

package sdd_pkg;

  localparam int MagW = 14;
  localparam int QuoW = 10;
  localparam int DigitCount = 4;
  localparam int CountW = 2;
  localparam int FifoDepth = 2;
  localparam int RecipShift = 16;

  localparam logic signed [15:0] DispMin = -16'sd999;
  localparam logic signed [15:0] DispMax = 16'sd9999;
  localparam logic [5:0] MinusCode = 6'h0A;
  localparam logic [5:0] DigitBase = 6'h30;
  localparam logic [12:0] Recip10 = 13'd6554;
  localparam logic [CountW-1:0] LastDigit = 2'd3;

  typedef struct packed {
    logic neg;
    logic [MagW-1:0] mag;
  } item_t;

endpackage

// File: rtl/sdd_front.sv
// Front end: takes a value beat, clamps it and splits it into sign and magnitude.
`timescale 1ns / 1ps

module sdd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] value_in_i,
  output logic               push_o,
  output sdd_pkg::item_t     item_o,
  input  logic               full_i
);
  import sdd_pkg::*;

  logic              valid_q, valid_d;
  item_t             item_q, item_d;
  logic signed [15:0] clamped;
  logic              load;

  always_comb begin
    priority if (value_in_i < DispMin) begin
      clamped = DispMin;
    end else if (value_in_i > DispMax) begin
      clamped = DispMax;
    end else begin
      clamped = value_in_i;
    end
  end

  always_comb begin
    logic [15:0] abs_val;
    abs_val = clamped[15] ? 16'(-clamped) : 16'(clamped);
    item_d.neg = clamped[15];
    item_d.mag = abs_val[MagW-1:0];
  end

  assign push_o = valid_q && !full_i;
  assign busy = valid_q && full_i;
  assign load = start && !busy;
  assign valid_d = load ? 1'b1 : (push_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/sdd_fifo.sv
// Two-entry queue that decouples the front end from the digit back end.
`timescale 1ns / 1ps

module sdd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sdd_pkg::item_t item_o
);
  import sdd_pkg::*;

  item_t      mem_q [FifoDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'(FifoDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/sdd_back.sv
// Back end: peels off one decimal digit per cycle and drives the digit writes.
`timescale 1ns / 1ps

module sdd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sdd_pkg::item_t item_i,
  output logic           pop_o,
  output logic           strobe_o,
  output logic [2:0]     digit_register_o,
  output logic [5:0]     digit_data_o,
  output logic           last_write_o
);
  import sdd_pkg::*;

  logic              active_q, active_d;
  logic [CountW-1:0] count_q, count_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [26:0]       prod;
  logic [QuoW-1:0]   quo;
  logic [MagW-1:0]   rem_full;
  logic [5:0]        data_d;
  logic              strobe_q;
  logic [2:0]        reg_q;
  logic [5:0]        data_q;
  logic              last_q;
  logic              at_last;

  assign at_last = (count_q == LastDigit);
  assign pop_o = valid_i && (!active_q || at_last);

  assign prod = 27'(mag_q) * 27'(Recip10);
  assign quo = prod[RecipShift +: QuoW];
  assign rem_full = mag_q - (MagW'(quo) * MagW'(10));

  always_comb begin
    if (at_last && neg_q) begin
      data_d = MinusCode;
    end else begin
      data_d = DigitBase + {2'b00, rem_full[3:0]};
    end
  end

  always_comb begin
    active_d = active_q;
    count_d = count_q;
    mag_d = mag_q;
    neg_d = neg_q;
    if (active_q) begin
      count_d = count_q + 2'd1;
      mag_d = MagW'(quo);
      if (at_last) begin
        active_d = 1'b0;
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      count_d = '0;
      mag_d = item_i.mag;
      neg_d = item_i.neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q <= '0;
      strobe_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      active_q <= active_d;
      count_q <= count_d;
      strobe_q <= active_q;
      last_q <= active_q && at_last;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    reg_q <= {1'b0, count_q} + 3'd1;
    data_q <= data_d;
  end

  assign strobe_o = strobe_q;
  assign digit_register_o = reg_q;
  assign digit_data_o = data_q;
  assign last_write_o = last_q;

endmodule

// File: rtl/signed_value_to_display_digits.sv
// Top level of the signed value to display digit writes converter.
//
//   Channel   Direction  Handshake         Payload
//   command   in         start, busy       value_in_i (16 bit signed)
//   digits    out        strobe_o          digit_register_o, digit_data_o, last_write_o
//
// Each value gives four digit beats on consecutive cycles, register 1 first.
// A new value can be taken every cycle until the queue fills; sustained, the single digit
// extraction unit in the back end takes a new value only as it computes the last digit.
// An accepted value passes the front register, the queue and the back end's registers.
// Reset clears the valid flags, queue pointers and digit counter; the receiver
// cannot stall, so busy rises only when the front register and queue are full.
`timescale 1ns / 1ps

module signed_value_to_display_digits (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] value_in_i,
  output logic               strobe_o,
  output logic [2:0]         digit_register_o,
  output logic [5:0]         digit_data_o,
  output logic               last_write_o
);
  import sdd_pkg::*;

  logic  push, full, pop, q_valid;
  item_t front_item, q_item;

  sdd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_in_i (value_in_i),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  sdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  sdd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .item_i           (q_item),
    .pop_o            (pop),
    .strobe_o         (strobe_o),
    .digit_register_o (digit_register_o),
    .digit_data_o     (digit_data_o),
    .last_write_o     (last_write_o)
  );

endmodule

// File: rtl/sdd_checker.sv
// Port-level checker for the converter and the bind that attaches it.
`timescale 1ns / 1ps

module sdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       strobe_o,
  input logic [2:0] digit_register_o,
  input logic [5:0] digit_data_o,
  input logic       last_write_o
);
  import sdd_pkg::*;

  a_last_on_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_write_o |-> strobe_o && digit_register_o == 3'd4)
    else $error("Last flag outside the fourth digit beat.");

  a_fourth_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && digit_register_o == 3'd4 |-> last_write_o)
    else $error("Fourth digit beat without last flag.");

  a_second_follows_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && digit_register_o == 3'd2 |->
      $past(strobe_o) && $past(digit_register_o) == 3'd1)
    else $error("Digit beat two does not follow beat one.");

  a_third_follows_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && digit_register_o == 3'd3 |->
      $past(strobe_o) && $past(digit_register_o) == 3'd2)
    else $error("Digit beat three does not follow beat two.");

  a_data_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (digit_data_o >= DigitBase && digit_data_o <= DigitBase + 6'd9) ||
      (digit_data_o == MinusCode && digit_register_o == 3'd4))
    else $error("Digit beat carries an invalid code.");

endmodule

bind signed_value_to_display_digits sdd_checker u_sdd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .strobe_o         (strobe_o),
  .digit_register_o (digit_register_o),
  .digit_data_o     (digit_data_o),
  .last_write_o     (last_write_o)
);
